/* hw/rtl/tle_pkg.sv */
// tle_pkg: shared types and constants for the terminal line editor
// no dependencies; imported by tle_line_mem and terminal_line_editor_core
`timescale 1ns / 1ps

package tle_pkg;

	localparam int CNT_W  = 6;
	localparam int BYTE_W = 8;
	localparam int KIND_W = 2;
	localparam int SKIP_W = 2;

	// control characters seen on the terminal side
	localparam logic [BYTE_W-1:0] CHR_CR  = 8'h0D;
	localparam logic [BYTE_W-1:0] CHR_BS  = 8'h08;
	localparam logic [BYTE_W-1:0] CHR_DEL = 8'h7F;
	localparam logic [BYTE_W-1:0] CHR_ESC = 8'h1B;
	localparam logic [BYTE_W-1:0] CHR_SP  = 8'h20;
	localparam logic [BYTE_W-1:0] CHR_BEL = 8'h07;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_ECHO = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CHAR = 2'd1;
	localparam logic [KIND_W-1:0] KIND_END  = 2'd2;

	// bytes dropped after an escape
	localparam logic [SKIP_W-1:0] SKIP_N = 2'd2;

	localparam logic [CNT_W-1:0] MAX_LEN_RST = 6'd32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_LINE,
		ST_BS,
		ST_END
	} tle_state_t;

	typedef enum logic [2:0] {
		CLS_CR,
		CLS_BS,
		CLS_ESC,
		CLS_PRINT,
		CLS_OTHER
	} tle_class_t;

	// line store access request
	typedef struct packed {
		logic              we;
		logic [CNT_W-1:0]  waddr;
		logic [BYTE_W-1:0] wdata;
		logic              re;
		logic [CNT_W-1:0]  raddr;
	} tle_mem_req_t;

	function automatic tle_class_t classify(input logic [BYTE_W-1:0] c);
		tle_class_t cls;
		if (c == CHR_CR)
			cls = CLS_CR;
		else if (c == CHR_BS || c == CHR_DEL)
			cls = CLS_BS;
		else if (c == CHR_ESC)
			cls = CLS_ESC;
		else if (c > CHR_SP && c < CHR_DEL)
			cls = CLS_PRINT;
		else
			cls = CLS_OTHER;
		return cls;
	endfunction

endpackage

/* hw/rtl/tle_line_mem.sv */
// tle_line_mem: synchronous line store, one write and one registered read port
// depends on tle_pkg for the request struct
`timescale 1ns / 1ps

module tle_line_mem #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic                       clk,
	input  tle_pkg::tle_mem_req_t      req,
	output logic [tle_pkg::BYTE_W-1:0] rdata
);
	import tle_pkg::*;

	logic [BYTE_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (req.we)
			mem[req.waddr[AW-1:0]] <= req.wdata;
	end

	// read port, data holds until the next read
	always_ff @(posedge clk) begin
		if (req.re)
			rdata <= mem[req.raddr[AW-1:0]];
	end

endmodule

/* hw/rtl/terminal_line_editor_core.sv */
// Terminal line editor. Takes one received byte at a time and answers with echo bytes, or on
// carriage return with the stored line one character per result and then a line-end result
// carrying the length; an escape and the two bytes after it give no result. While the output
// side takes each result at once, the single read port of the line store sets the pace of one
// stored character per cycle. No new byte is taken until the previous one has placed its last
// result in the output register, which may still be waiting to be taken.
// depends on tle_pkg and tle_line_mem
`timescale 1ns / 1ps

module terminal_line_editor_core #(
	parameter int LINE_DEPTH = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wen,
	input  logic [tle_pkg::CNT_W-1:0]  cfg_wdata,
	input  logic                       rx_valid,
	output logic                       rx_ready,
	input  logic [tle_pkg::BYTE_W-1:0] rx_byte,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [tle_pkg::KIND_W-1:0] out_kind,
	output logic [tle_pkg::BYTE_W-1:0] out_byte,
	output logic [tle_pkg::CNT_W-1:0]  line_length,
	output logic                       last
);
	import tle_pkg::*;

	localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LINE_DEPTH);

	tle_state_t state_q, state_d;

	logic [CNT_W-1:0]  max_len_q;
	logic [CNT_W-1:0]  char_count_q, cnt_d;
	logic [SKIP_W-1:0] skip_q, skip_d;
	logic [CNT_W-1:0]  idx_q, idx_d;
	logic              bs_q, bs_d;
	logic [BYTE_W-1:0] byte_q;

	logic              out_valid_q;
	logic [KIND_W-1:0] out_kind_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic [CNT_W-1:0]  out_len_q;
	logic              out_last_q;

	logic              ld;
	logic [KIND_W-1:0] o_kind;
	logic [BYTE_W-1:0] o_byte;
	logic [CNT_W-1:0]  o_len;
	logic              o_last;

	tle_mem_req_t      mreq;
	logic [BYTE_W-1:0] rdata;

	logic              out_free;
	logic [CNT_W-1:0]  lim;
	logic [CNT_W-1:0]  idx_nx;
	tle_class_t        cls;

	assign out_free = !out_valid_q || out_ready;
	assign lim      = (max_len_q > DEPTH_C) ? DEPTH_C : max_len_q;
	assign idx_nx   = idx_q + CNT_W'(1);
	assign cls      = classify(byte_q);

	tle_line_mem #(
		.DEPTH(LINE_DEPTH),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.req  (mreq),
		.rdata(rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (rx_valid)
					state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (skip_q != '0) begin
					state_d = ST_IDLE;
				end else begin
					unique case (cls)
						CLS_CR:  state_d = (char_count_q != '0) ? ST_LINE : ST_END;
						CLS_ESC: state_d = ST_IDLE;
						CLS_BS: begin
							if (out_free)
								state_d = (char_count_q != '0) ? ST_BS : ST_IDLE;
						end
						default: begin
							if (out_free)
								state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_LINE: begin
				if (out_free && idx_nx >= char_count_q)
					state_d = ST_END;
			end
			ST_BS: begin
				if (out_free && bs_q)
					state_d = ST_IDLE;
			end
			ST_END: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath control and result selection
	always_comb begin
		ld     = 1'b0;
		o_kind = KIND_ECHO;
		o_byte = '0;
		o_len  = '0;
		o_last = 1'b0;
		mreq   = '0;
		cnt_d  = char_count_q;
		skip_d = skip_q;
		idx_d  = idx_q;
		bs_d   = bs_q;
		rx_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: rx_ready = 1'b1;
			ST_EXEC: begin
				if (skip_q != '0) begin
					skip_d = skip_q - SKIP_W'(1);
				end else begin
					unique case (cls)
						CLS_CR: begin
							if (char_count_q != '0) begin
								mreq.re    = 1'b1;
								mreq.raddr = '0;
								idx_d      = '0;
							end
						end
						CLS_ESC: skip_d = SKIP_N;
						CLS_BS: begin
							if (out_free) begin
								ld = 1'b1;
								if (char_count_q != '0) begin
									o_byte = CHR_BS;
									cnt_d  = char_count_q - CNT_W'(1);
									bs_d   = 1'b0;
								end else begin
									o_byte = CHR_BEL;
									o_last = 1'b1;
								end
							end
						end
						CLS_PRINT: begin
							if (out_free) begin
								ld     = 1'b1;
								o_last = 1'b1;
								if (char_count_q < lim) begin
									mreq.we    = 1'b1;
									mreq.waddr = char_count_q;
									mreq.wdata = byte_q;
									o_byte     = byte_q;
									cnt_d      = char_count_q + CNT_W'(1);
								end else begin
									o_byte = CHR_BEL;
								end
							end
						end
						default: begin
							if (out_free) begin
								ld     = 1'b1;
								o_byte = CHR_BEL;
								o_last = 1'b1;
							end
						end
					endcase
				end
			end
			ST_LINE: begin
				if (out_free) begin
					ld     = 1'b1;
					o_kind = KIND_CHAR;
					o_byte = rdata;
					idx_d  = idx_nx;
					if (idx_nx < char_count_q) begin
						mreq.re    = 1'b1;
						mreq.raddr = idx_nx;
					end
				end
			end
			ST_BS: begin
				if (out_free) begin
					ld = 1'b1;
					if (!bs_q) begin
						o_byte = CHR_SP;
						bs_d   = 1'b1;
					end else begin
						o_byte = CHR_BS;
						o_last = 1'b1;
					end
				end
			end
			ST_END: begin
				if (out_free) begin
					ld     = 1'b1;
					o_kind = KIND_END;
					o_len  = char_count_q;
					o_last = 1'b1;
					cnt_d  = '0;
				end
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			max_len_q    <= MAX_LEN_RST;
			char_count_q <= '0;
			skip_q       <= '0;
			idx_q        <= '0;
			bs_q         <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			char_count_q <= cnt_d;
			skip_q       <= skip_d;
			idx_q        <= idx_d;
			bs_q         <= bs_d;
			if (cfg_wen)
				max_len_q <= cfg_wdata;
			if (ld)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (rx_valid && rx_ready)
			byte_q <= rx_byte;
		if (ld) begin
			out_kind_q <= o_kind;
			out_byte_q <= o_byte;
			out_len_q  <= o_len;
			out_last_q <= o_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_kind    = out_kind_q;
	assign out_byte    = out_byte_q;
	assign line_length = out_len_q;
	assign last        = out_last_q;

	// count never runs past the line store
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		char_count_q <= DEPTH_C)
		else $error("char count beyond line depth");

	// line readout only covers stored characters
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LINE |-> idx_q < char_count_q)
		else $error("line readout index beyond count");

	// writes only while executing a byte, and only into free room
	a_write_room: assert property (@(posedge clk) disable iff (!arst_n)
		mreq.we |-> (state_q == ST_EXEC && char_count_q < DEPTH_C))
		else $error("line store write out of place");

	// line end leaves an end result and an empty line
	a_line_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_END && out_free) |=>
			(out_valid && out_kind == KIND_END && last && char_count_q == '0))
		else $error("line end not delivered");

endmodule
